>>> rtl/core/filled_circle_span_generator_defines.svh
// Assertion macros shared by the span generator modules.
// Each macro expects clk and rst_n in scope.
`ifndef FILLED_CIRCLE_SPAN_GENERATOR_DEFINES_SVH
`define FILLED_CIRCLE_SPAN_GENERATOR_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define FCSG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcsg check failed");

// Next-cycle implication
`define FCSG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcsg check failed");

`else

`define FCSG_ASSERT_NOW(label, ante, cons)
`define FCSG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> rtl/core/fcsg_pkg.sv
package fcsg_pkg;

  // Default sizes
  localparam int MAX_RADIUS_DEF = 63;
  localparam int COORD_BITS_DEF = 12;

  // Fixed field and loop limits
  localparam int RADIUS_BITS = 6;
  localparam int MAX_RESULTS = 48;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;  // latch a new circle
    logic step;  // emit one result and advance the loop
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
    logic last;      // the current step is the final one
  } sts_t;

endpackage

>>> rtl/core/fcsg_ctrl.sv
`include "filled_circle_span_generator_defines.svh"

module fcsg_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  fcsg_pkg::sts_t  sts,
  output fcsg_pkg::cmd_t  cmd
);

  fcsg_pkg::state_t state_r;
  fcsg_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcsg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fcsg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = fcsg_pkg::ST_RUN;
        end
      end
      fcsg_pkg::ST_RUN: begin
        if (sts.out_free && sts.last) begin
          state_nxt = fcsg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fcsg_pkg::ST_IDLE;
    endcase
  end

  // Outputs; no transfer is taken while reset is held
  always_comb begin
    in_stall = 1'b1;
    cmd      = '0;
    unique case (state_r)
      fcsg_pkg::ST_IDLE: begin
        in_stall = !rst_n;
        cmd.load = in_valid && rst_n;
      end
      fcsg_pkg::ST_RUN: begin
        cmd.step = sts.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  `FCSG_ASSERT_NEXT(a_load_starts_run, cmd.load, state_r == fcsg_pkg::ST_RUN)
  `FCSG_ASSERT_NEXT(a_last_ends_run, cmd.step && sts.last, state_r == fcsg_pkg::ST_IDLE)

endmodule

>>> rtl/core/fcsg_datapath.sv
`include "filled_circle_span_generator_defines.svh"

module fcsg_datapath #(
  parameter int MAX_RADIUS = fcsg_pkg::MAX_RADIUS_DEF,
  parameter int COORD_BITS = fcsg_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  fcsg_pkg::cmd_t                      cmd,
  output fcsg_pkg::sts_t                      sts,
  input  logic signed [COORD_BITS-1:0]        in_center_x,
  input  logic signed [COORD_BITS-1:0]        in_center_y,
  input  logic [fcsg_pkg::RADIUS_BITS-1:0]    in_circle_radius,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COORD_BITS:0]          out_wide_x_left,
  output logic signed [COORD_BITS:0]          out_wide_x_right,
  output logic signed [COORD_BITS:0]          out_wide_row_below,
  output logic signed [COORD_BITS:0]          out_wide_row_above,
  output logic signed [COORD_BITS:0]          out_narrow_x_left,
  output logic signed [COORD_BITS:0]          out_narrow_x_right,
  output logic signed [COORD_BITS:0]          out_narrow_row_below,
  output logic signed [COORD_BITS:0]          out_narrow_row_above,
  output logic                                out_last_step
);

  localparam int OFS_BITS = $clog2(MAX_RADIUS + 1);
  localparam int DW       = OFS_BITS + 3;
  localparam int OW       = COORD_BITS + 1;
  localparam int SW       = ((COORD_BITS > OFS_BITS) ? COORD_BITS : OFS_BITS) + 2;
  localparam int RW       = ((fcsg_pkg::RADIUS_BITS > OFS_BITS) ?
                             fcsg_pkg::RADIUS_BITS : OFS_BITS) + 1;
  localparam int CW       = $clog2(fcsg_pkg::MAX_RESULTS);

  localparam logic signed [DW-1:0] D_ONE = DW'(1);
  localparam logic signed [DW-1:0] D_TWO = DW'(2);

  // Loop state
  logic signed [COORD_BITS-1:0] cx_r, cy_r;
  logic [OFS_BITS-1:0]          rad_r, ox_r, oy_r;
  logic signed [DW-1:0]         d_r;
  logic [CW-1:0]                cnt_r;

  logic [OFS_BITS-1:0]          rad_sat;
  logic [OFS_BITS-1:0]          ox_nxt, oy_nxt;
  logic signed [DW-1:0]         d_nxt;
  logic signed [DW-1:0]         ox2, oy2, rmo2;
  logic [OFS_BITS:0]            oxe, oye;
  logic                         cont;

  // Output register
  logic                         out_valid_r;
  logic signed [OW-1:0]         wxl_r, wxr_r, wrb_r, wra_r;
  logic signed [OW-1:0]         nxl_r, nxr_r, nrb_r, nra_r;
  logic                         last_r;

  logic signed [SW-1:0]         cx_w, cy_w, ox_w, oy_w;

  // Radius clamp
  always_comb begin
    if (RW'(in_circle_radius) > RW'(MAX_RADIUS)) begin
      rad_sat = OFS_BITS'(MAX_RADIUS);
    end else begin
      rad_sat = OFS_BITS'(in_circle_radius);
    end
  end

  // Midpoint decision step
  always_comb begin
    ox2  = DW'({ox_r, 1'b0});
    oy2  = DW'({oy_r, 1'b0});
    rmo2 = DW'({OFS_BITS'(rad_r - oy_r), 1'b0});
    oxe  = {1'b0, ox_r};
    oye  = {1'b0, oy_r};
    if (d_r >= ox2) begin
      d_nxt  = d_r - ox2 - D_ONE;
      ox_nxt = ox_r + OFS_BITS'(1);
      oy_nxt = oy_r;
      cont   = oye >= (oxe + (OFS_BITS+1)'(1));
    end else if (d_r < rmo2) begin
      d_nxt  = d_r + oy2 - D_ONE;
      ox_nxt = ox_r;
      oy_nxt = oy_r - OFS_BITS'(1);
      cont   = oye > oxe;
    end else begin
      d_nxt  = d_r + oy2 - ox2 - D_TWO;
      ox_nxt = ox_r + OFS_BITS'(1);
      oy_nxt = oy_r - OFS_BITS'(1);
      cont   = oye >= (oxe + (OFS_BITS+1)'(2));
    end
  end

  // Status to the controller
  always_comb begin
    sts.out_free = !out_valid_r || !out_stall;
    sts.last     = !cont || (cnt_r == CW'(fcsg_pkg::MAX_RESULTS - 1));
  end

  // Loop registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx_r  <= in_center_x;
      cy_r  <= in_center_y;
      rad_r <= rad_sat;
      ox_r  <= '0;
      oy_r  <= rad_sat;
      d_r   <= DW'(rad_sat) - D_ONE;
      cnt_r <= '0;
    end else if (cmd.step) begin
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      d_r   <= d_nxt;
      cnt_r <= cnt_r + CW'(1);
    end
  end

  // Span ends at the current offsets
  always_comb begin
    cx_w = SW'(cx_r);
    cy_w = SW'(cy_r);
    ox_w = SW'(ox_r);
    oy_w = SW'(oy_r);
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      wxl_r  <= OW'(cx_w - oy_w);
      wxr_r  <= OW'(cx_w + oy_w);
      wrb_r  <= OW'(cy_w + ox_w);
      wra_r  <= OW'(cy_w - ox_w);
      nxl_r  <= OW'(cx_w - ox_w);
      nxr_r  <= OW'(cx_w + ox_w);
      nrb_r  <= OW'(cy_w + oy_w);
      nra_r  <= OW'(cy_w - oy_w);
      last_r <= sts.last;
    end
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_wide_x_left      = wxl_r;
  assign out_wide_x_right     = wxr_r;
  assign out_wide_row_below   = wrb_r;
  assign out_wide_row_above   = wra_r;
  assign out_narrow_x_left    = nxl_r;
  assign out_narrow_x_right   = nxr_r;
  assign out_narrow_row_below = nrb_r;
  assign out_narrow_row_above = nra_r;
  assign out_last_step        = last_r;

  `FCSG_ASSERT_NOW(a_step_has_room, cmd.step, sts.out_free)
  `FCSG_ASSERT_NOW(a_step_in_octant, cmd.step, oy_r >= ox_r)
  `FCSG_ASSERT_NEXT(a_load_inits, cmd.load, (ox_r == '0) && (oy_r == rad_r) && (cnt_r == '0))

endmodule

>>> rtl/core/filled_circle_span_generator.sv
// Filled circle span generator.
// Input channel (in_valid/in_stall): one circle per transfer, signed center
// in_center_x/in_center_y and in_circle_radius (clamped to MAX_RADIUS).
// Output channel (out_valid/out_stall): one transfer per midpoint step, each
// carrying two wide spans (rows center_y +/- offset_x) and two narrow spans
// (rows center_y +/- offset_y); out_last_step marks the circle's final step.
// A circle of radius r gives about r/sqrt(2)+1 transfers, at most 48.
// Timing: the circle is latched into the loop registers, then the decision
// unit runs one step per cycle into the output register whenever that
// register can take a result (empty, or out_stall low).
// A new circle is taken the cycle after the final step is computed, while
// that final result may still sit in the output register.
// If out_valid and out_stall are high, the output register and step loop hold.
// Reset (rst_n low, synchronous) returns the controller to idle and drops
// out_valid; a circle in progress is discarded.
module filled_circle_span_generator #(
  parameter int MAX_RADIUS = fcsg_pkg::MAX_RADIUS_DEF,
  parameter int COORD_BITS = fcsg_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COORD_BITS-1:0]     in_center_x,
  input  logic signed [COORD_BITS-1:0]     in_center_y,
  input  logic [fcsg_pkg::RADIUS_BITS-1:0] in_circle_radius,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [COORD_BITS:0]       out_wide_x_left,
  output logic signed [COORD_BITS:0]       out_wide_x_right,
  output logic signed [COORD_BITS:0]       out_wide_row_below,
  output logic signed [COORD_BITS:0]       out_wide_row_above,
  output logic signed [COORD_BITS:0]       out_narrow_x_left,
  output logic signed [COORD_BITS:0]       out_narrow_x_right,
  output logic signed [COORD_BITS:0]       out_narrow_row_below,
  output logic signed [COORD_BITS:0]       out_narrow_row_above,
  output logic                             out_last_step
);

  fcsg_pkg::cmd_t cmd;
  fcsg_pkg::sts_t sts;

  // Sequencer
  fcsg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Decision loop and output register
  fcsg_datapath #(
    .MAX_RADIUS (MAX_RADIUS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_center_x          (in_center_x),
    .in_center_y          (in_center_y),
    .in_circle_radius     (in_circle_radius),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_wide_x_left      (out_wide_x_left),
    .out_wide_x_right     (out_wide_x_right),
    .out_wide_row_below   (out_wide_row_below),
    .out_wide_row_above   (out_wide_row_above),
    .out_narrow_x_left    (out_narrow_x_left),
    .out_narrow_x_right   (out_narrow_x_right),
    .out_narrow_row_below (out_narrow_row_below),
    .out_narrow_row_above (out_narrow_row_above),
    .out_last_step        (out_last_step)
  );

endmodule
